// File: rtl/core/optical_flow_error_accumulator_macros.svh
// assertion macros shared by the optical flow error accumulator rtl
// expects clk_i and rst_ni in the scope where a macro is used
`ifndef OPTICAL_FLOW_ERROR_ACCUMULATOR_MACROS_SVH
`define OPTICAL_FLOW_ERROR_ACCUMULATOR_MACROS_SVH

// antecedent implies consequent in the same cycle
`define OFEA_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("ofea assertion failed");

// expression holds on every clock edge out of reset
`define OFEA_ASSERT_ALWAYS(lbl, expr) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (expr)) \
    else $error("ofea assertion failed");

`endif

// File: rtl/core/ofea_pkg.sv
// shared types, constants and tables for the optical flow error accumulator
// no dependencies
`default_nettype none

package ofea_pkg;

  localparam int unsigned FLOW_W     = 24;
  localparam int unsigned CFG_W      = 24;
  localparam int unsigned LIMIT_W    = 23;
  localparam int unsigned MEAN_A_W   = 16;
  localparam int unsigned MEAN_E_W   = 24;
  localparam int unsigned COUNT_W    = 23;
  localparam int unsigned CNT_W      = 25;
  localparam int unsigned MUL_W      = 33;
  localparam int unsigned PROD_W     = 2 * MUL_W;
  localparam int unsigned MAG_W      = 52;
  localparam int unsigned SUM_W      = 48;
  localparam int unsigned SQ_W       = 48;
  localparam int unsigned RAD_W      = 64;
  localparam int unsigned ROOT_W     = RAD_W / 2;
  localparam int unsigned SREM_W     = ROOT_W + 3;
  localparam int unsigned CX_W       = 36;
  localparam int unsigned CZ_W       = 34;
  localparam int unsigned ITER_W     = 5;
  localparam int unsigned DIVS_W     = CNT_W;

  localparam int unsigned MAX_PIXELS_DEF = 4194304;
  localparam int unsigned FLOW_FRAC_DEF  = 8;
  localparam int unsigned ANGLE_FRAC_DEF = 14;

  localparam int unsigned CORDIC_FRAC  = 30;
  localparam int unsigned CORDIC_ITERS = 28;
  localparam logic [CZ_W-1:0] PI_Q30      = 34'd3373259426;
  localparam logic [CZ_W-1:0] HALF_PI_Q30 = 34'd1686629713;

  // mode codes
  localparam logic [1:0] MODE_ALL    = 2'd0;
  localparam logic [1:0] MODE_MASKED = 2'd1;
  localparam logic [1:0] MODE_BAND   = 2'd2;

  // register indexes
  localparam logic [1:0] REG_MODE    = 2'd0;
  localparam logic [1:0] REG_LIMIT   = 2'd1;
  localparam logic [1:0] REG_BAND_LO = 2'd2;
  localparam logic [1:0] REG_BAND_HI = 2'd3;

  localparam logic [LIMIT_W-1:0] LIMIT_RST   = 23'd2560000;
  localparam logic [CFG_W-1:0]   BAND_HI_RST = 24'hFFFFFF;

  typedef struct packed {
    logic signed [FLOW_W-1:0] est_u;
    logic signed [FLOW_W-1:0] est_v;
    logic signed [FLOW_W-1:0] gt_u;
    logic signed [FLOW_W-1:0] gt_v;
    logic                     occluded;
    logic                     last_pixel;
    logic                     est_ok;
    logic                     gt_ok;
  } item_t;

  typedef struct packed {
    logic [MEAN_A_W-1:0] mean_a;
    logic [MEAN_E_W-1:0] mean_e;
    logic [COUNT_W-1:0]  count;
  } res_t;

  typedef struct packed {
    logic             busy;
    logic [CNT_W-1:0] count;
  } back_stat_t;

  function automatic logic [FLOW_W-1:0] abs_flow(input logic signed [FLOW_W-1:0] v);
    abs_flow = v[FLOW_W-1] ? FLOW_W'(-v) : FLOW_W'(v);
  endfunction

  // atan(2^-i) in q30, truncated
  function automatic logic [CZ_W-1:0] atan_q30(input logic [ITER_W-1:0] i);
    case (i)
      5'd0:    atan_q30 = 34'd843314856;
      5'd1:    atan_q30 = 34'd497837829;
      5'd2:    atan_q30 = 34'd263043836;
      5'd3:    atan_q30 = 34'd133525158;
      5'd4:    atan_q30 = 34'd67021686;
      5'd5:    atan_q30 = 34'd33543515;
      5'd6:    atan_q30 = 34'd16775850;
      5'd7:    atan_q30 = 34'd8388437;
      5'd8:    atan_q30 = 34'd4194282;
      5'd9:    atan_q30 = 34'd2097149;
      default: atan_q30 = (34'd1 << (5'd30 - i)) - 34'd1;
    endcase
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/ofea_front.sv
// front end: takes pixel words, checks component limits, holds a two-entry queue
// depends on ofea_pkg
`default_nettype none

module ofea_front
  import ofea_pkg::*;
(
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     push_i,
  output logic                          full_o,
  input  wire logic signed [FLOW_W-1:0] est_u_i,
  input  wire logic signed [FLOW_W-1:0] est_v_i,
  input  wire logic signed [FLOW_W-1:0] gt_u_i,
  input  wire logic signed [FLOW_W-1:0] gt_v_i,
  input  wire logic                     occluded_i,
  input  wire logic                     last_pixel_i,
  input  wire logic [LIMIT_W-1:0]       limit_i,
  input  wire logic                     pop_i,
  output logic                          empty_o,
  output item_t                         item_o
);

  item_t      slot_q [2];
  logic       wr_q, rd_q;
  logic [1:0] level_q;
  logic       do_push, do_pop;
  item_t      new_item;
  logic [FLOW_W-1:0] lim;

  assign lim     = {1'b0, limit_i};
  assign full_o  = (level_q == 2'd2);
  assign empty_o = (level_q == 2'd0);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign item_o  = slot_q[rd_q];

  always_comb begin
    new_item.est_u      = est_u_i;
    new_item.est_v      = est_v_i;
    new_item.gt_u       = gt_u_i;
    new_item.gt_v       = gt_v_i;
    new_item.occluded   = occluded_i;
    new_item.last_pixel = last_pixel_i;
    new_item.est_ok     = (abs_flow(est_u_i) < lim) && (abs_flow(est_v_i) < lim);
    new_item.gt_ok      = (abs_flow(gt_u_i) < lim) && (abs_flow(gt_v_i) < lim);
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_q] <= new_item;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= 1'b0;
      rd_q    <= 1'b0;
      level_q <= 2'd0;
    end else begin
      if (do_push) wr_q <= !wr_q;
      if (do_pop)  rd_q <= !rd_q;
      level_q <= level_q + 2'(do_push) - 2'(do_pop);
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/ofea_isqrt.sv
// iterative integer square root, two radicand bits per cycle
// depends on ofea_pkg
`default_nettype none

module ofea_isqrt
  import ofea_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic [RAD_W-1:0]  rad_i,
  output logic                   busy_o,
  output logic [ROOT_W-1:0]      root_o,
  output logic [SREM_W-1:0]      rem_o
);

  logic [RAD_W-1:0]  rad_q;
  logic [ROOT_W-1:0] root_q;
  logic [SREM_W-1:0] rem_q;
  logic [ITER_W-1:0] it_q;
  logic              busy_q;
  logic [SREM_W-1:0] part, trial;
  logic              fits;

  assign part   = {rem_q[SREM_W-3:0], rad_q[RAD_W-1 -: 2]};
  assign trial  = {1'b0, root_q, 2'b01};
  assign fits   = (part >= trial);
  assign busy_o = busy_q;
  assign root_o = root_q;
  assign rem_o  = rem_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      it_q   <= '0;
      rad_q  <= '0;
      root_q <= '0;
      rem_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      it_q   <= ITER_W'(ROOT_W - 1);
      rad_q  <= rad_i;
      root_q <= '0;
      rem_q  <= '0;
    end else if (busy_q) begin
      rad_q  <= rad_q << 2;
      rem_q  <= fits ? (part - trial) : part;
      root_q <= {root_q[ROOT_W-2:0], fits};
      if (it_q == '0) busy_q <= 1'b0;
      else            it_q   <= it_q - 1'b1;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/ofea_div.sv
// restoring divider, one quotient bit per cycle
// depends on ofea_pkg
`default_nettype none

module ofea_div
  import ofea_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic [SUM_W-1:0]  dvd_i,
  input  wire logic [DIVS_W-1:0] dvs_i,
  output logic                   busy_o,
  output logic [SUM_W-1:0]       quot_o
);

  localparam int unsigned DCNT_W = $clog2(SUM_W);

  logic [SUM_W-1:0]  dvd_q;
  logic [DIVS_W-1:0] dvs_q;
  logic [DIVS_W-1:0] rem_q;
  logic [DCNT_W-1:0] it_q;
  logic              busy_q;
  logic [DIVS_W:0]   part;
  logic              fits;

  assign part   = {rem_q, dvd_q[SUM_W-1]};
  assign fits   = (part >= {1'b0, dvs_q});
  assign busy_o = busy_q;
  assign quot_o = dvd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      it_q   <= '0;
      dvd_q  <= '0;
      dvs_q  <= '0;
      rem_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      it_q   <= DCNT_W'(SUM_W - 1);
      dvd_q  <= dvd_i;
      dvs_q  <= dvs_i;
      rem_q  <= '0;
    end else if (busy_q) begin
      rem_q <= fits ? DIVS_W'(part - {1'b0, dvs_q}) : DIVS_W'(part);
      dvd_q <= {dvd_q[SUM_W-2:0], fits};
      if (it_q == '0) busy_q <= 1'b0;
      else            it_q   <= it_q - 1'b1;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/ofea_back.sv
// back end sequencer: qualifies pixels, endpoint and angular error, frame means
// depends on ofea_pkg, ofea_isqrt, ofea_div
`default_nettype none

module ofea_back
  import ofea_pkg::*;
#(
  parameter int unsigned MAX_PIXELS      = MAX_PIXELS_DEF,
  parameter int unsigned FLOW_FRAC_BITS  = FLOW_FRAC_DEF,
  parameter int unsigned ANGLE_FRAC_BITS = ANGLE_FRAC_DEF
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             q_empty_i,
  input  wire item_t            q_item_i,
  output logic                  q_pop_o,
  input  wire logic [1:0]       mode_i,
  input  wire logic [CFG_W-1:0] band_lo_i,
  input  wire logic [CFG_W-1:0] band_hi_i,
  output logic                  res_valid_o,
  output res_t                  res_o,
  input  wire logic             res_ready_i,
  output back_stat_t            stat_o
);

  localparam int unsigned RSH = CORDIC_FRAC - ANGLE_FRAC_BITS;
  localparam logic [CZ_W:0] RND = (CZ_W+1)'(1) << (RSH - 1);
  localparam logic signed [PROD_W-1:0] SS = PROD_W'(1) << (2 * FLOW_FRAC_BITS);

  typedef enum logic [27:0] {
    S_IDLE = 28'h0000001, S_M0 = 28'h0000002, S_M1 = 28'h0000004,
    S_M2   = 28'h0000008, S_M3 = 28'h0000010, S_M4 = 28'h0000020,
    S_E1   = 28'h0000040, S_E2 = 28'h0000080, S_E3 = 28'h0000100,
    S_A1   = 28'h0000200, S_A2 = 28'h0000400, S_A3 = 28'h0000800,
    S_A4   = 28'h0001000, S_SH = 28'h0002000, S_Q0 = 28'h0004000,
    S_Q1   = 28'h0008000, S_Q2 = 28'h0010000, S_Q3 = 28'h0020000,
    S_Q4   = 28'h0040000, S_CR = 28'h0080000, S_AC = 28'h0100000,
    S_FIN  = 28'h0200000, S_D1 = 28'h0400000, S_D2 = 28'h0800000,
    S_OUT  = 28'h1000000
  } state_e;

  state_e state_q, state_d;
  item_t  item_q;
  logic signed [PROD_W-1:0] prod_q, acc_q;
  logic [SQ_W-1:0]   sq_q, blsq_q;
  logic [SUM_W-1:0]  esum_q, asum_q;
  logic [CNT_W-1:0]  cnt_q;
  logic              dot_neg_q;
  logic [MAG_W-1:0]  mdot_q, mx_q, my_q, mz_q;
  logic signed [CX_W-1:0] x_q, y_q;
  logic signed [CZ_W-1:0] z_q;
  logic [ITER_W-1:0] it_q;
  logic [MEAN_A_W-1:0] mean_a_q;
  logic [MEAN_E_W-1:0] mean_e_q;

  logic signed [MUL_W-1:0] mul_a, mul_b;
  logic signed [FLOW_W:0]  du, dv;
  logic [FLOW_W:0]         du_mag, dv_mag;
  logic signed [PROD_W-1:0] dot, cz;
  logic qual, take, big, cr_done;
  logic sq_start, sq_busy, dv_start, dv_busy;
  logic [ROOT_W-1:0] sq_root;
  logic [SREM_W-1:0] sq_rem;
  logic [SUM_W-1:0]  dv_dvd, dv_quot;
  logic [ROOT_W:0]   ep_round;
  logic [MEAN_E_W-1:0] ep_sat;
  logic [RAD_W-1:0]  rad;
  logic signed [CX_W-1:0] dx, dy;
  logic [CZ_W-1:0]   zc;
  logic [CZ_W:0]     ang;

  function automatic logic [PROD_W-1:0] abs_p(input logic signed [PROD_W-1:0] v);
    abs_p = v[PROD_W-1] ? PROD_W'(-v) : PROD_W'(v);
  endfunction

  assign du     = (FLOW_W+1)'(item_q.est_u) - (FLOW_W+1)'(item_q.gt_u);
  assign dv     = (FLOW_W+1)'(item_q.est_v) - (FLOW_W+1)'(item_q.gt_v);
  assign du_mag = du[FLOW_W] ? (FLOW_W+1)'(-du) : (FLOW_W+1)'(du);
  assign dv_mag = dv[FLOW_W] ? (FLOW_W+1)'(-dv) : (FLOW_W+1)'(dv);
  assign dot    = acc_q + prod_q + SS;
  assign cz     = acc_q - prod_q;
  assign big    = (|mdot_q[MAG_W-1:31]) | (|mx_q[MAG_W-1:31]) |
                  (|my_q[MAG_W-1:31]) | (|mz_q[MAG_W-1:31]);
  assign cr_done = (it_q == ITER_W'(CORDIC_ITERS)) || (y_q == '0);
  assign dx     = y_q >>> it_q;
  assign dy     = x_q >>> it_q;

  always_comb begin
    case (mode_i)
      MODE_MASKED: qual = item_q.est_ok && !item_q.occluded;
      MODE_BAND:   qual = item_q.est_ok && (sq_q >= blsq_q) && (sq_q <= prod_q[SQ_W-1:0]);
      default:     qual = item_q.est_ok && item_q.gt_ok;
    endcase
  end
  assign take = qual && (cnt_q < CNT_W'(MAX_PIXELS));

  // endpoint error rounding and saturation
  assign ep_round = {1'b0, sq_root} + (ROOT_W+1)'(sq_rem > {3'b0, sq_root});
  assign ep_sat   = (ep_round > (ROOT_W+1)'(24'hFFFFFF)) ? 24'hFFFFFF
                                                          : ep_round[MEAN_E_W-1:0];

  // clamp angle to [0, pi] and round to the output precision
  assign zc  = z_q[CZ_W-1] ? '0 : ((z_q > $signed(PI_Q30)) ? PI_Q30 : z_q);
  assign ang = ({1'b0, zc} + RND) >> RSH;

  // shared multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      S_M0: begin mul_a = MUL_W'(item_q.gt_u); mul_b = MUL_W'(item_q.gt_u); end
      S_M1: begin mul_a = MUL_W'(item_q.gt_v); mul_b = MUL_W'(item_q.gt_v); end
      S_M2: begin
        mul_a = $signed(MUL_W'(band_lo_i)); mul_b = $signed(MUL_W'(band_lo_i));
      end
      S_M3: begin
        mul_a = $signed(MUL_W'(band_hi_i)); mul_b = $signed(MUL_W'(band_hi_i));
      end
      S_M4: begin mul_a = MUL_W'(du); mul_b = MUL_W'(du); end
      S_E1: begin mul_a = MUL_W'(dv); mul_b = MUL_W'(dv); end
      S_E3: begin mul_a = MUL_W'(item_q.est_u); mul_b = MUL_W'(item_q.gt_u); end
      S_A1: begin mul_a = MUL_W'(item_q.est_v); mul_b = MUL_W'(item_q.gt_v); end
      S_A2: begin mul_a = MUL_W'(item_q.est_u); mul_b = MUL_W'(item_q.gt_v); end
      S_A3: begin mul_a = MUL_W'(item_q.est_v); mul_b = MUL_W'(item_q.gt_u); end
      S_Q0: begin
        mul_a = $signed({2'b0, mx_q[30:0]}); mul_b = $signed({2'b0, mx_q[30:0]});
      end
      S_Q1: begin
        mul_a = $signed({2'b0, my_q[30:0]}); mul_b = $signed({2'b0, my_q[30:0]});
      end
      S_Q2: begin
        mul_a = $signed({2'b0, mz_q[30:0]}); mul_b = $signed({2'b0, mz_q[30:0]});
      end
      default: ;
    endcase
  end

  always_comb begin
    state_d  = state_q;
    q_pop_o  = 1'b0;
    sq_start = 1'b0;
    dv_start = 1'b0;
    rad      = RAD_W'(acc_q + prod_q);
    dv_dvd   = asum_q;
    unique case (state_q)
      S_IDLE: if (!q_empty_i) begin
        q_pop_o = 1'b1;
        state_d = S_M0;
      end
      S_M0: state_d = S_M1;
      S_M1: state_d = S_M2;
      S_M2: state_d = S_M3;
      S_M3: state_d = S_M4;
      S_M4: state_d = take ? S_E1 : S_FIN;
      S_E1: state_d = S_E2;
      S_E2: begin
        sq_start = 1'b1;
        state_d  = S_E3;
      end
      S_E3: if (!sq_busy) state_d = (mode_i == MODE_BAND) ? S_FIN : S_A1;
      S_A1: state_d = S_A2;
      S_A2: state_d = S_A3;
      S_A3: state_d = S_A4;
      S_A4: state_d = S_SH;
      S_SH: if (!big) state_d = S_Q0;
      S_Q0: state_d = S_Q1;
      S_Q1: state_d = S_Q2;
      S_Q2: state_d = S_Q3;
      S_Q3: begin
        sq_start = 1'b1;
        state_d  = S_Q4;
      end
      S_Q4: if (!sq_busy) state_d = S_CR;
      S_CR: if (cr_done) state_d = S_AC;
      S_AC: state_d = S_FIN;
      S_FIN: begin
        if (!item_q.last_pixel)  state_d = S_IDLE;
        else if (cnt_q == '0)    state_d = S_OUT;
        else begin
          dv_start = 1'b1;
          state_d  = S_D1;
        end
      end
      S_D1: if (!dv_busy) begin
        dv_start = 1'b1;
        dv_dvd   = esum_q;
        state_d  = S_D2;
      end
      S_D2: if (!dv_busy) state_d = S_OUT;
      S_OUT: if (res_ready_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    prod_q <= mul_a * mul_b;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      item_q    <= '0;
      acc_q     <= '0;
      sq_q      <= '0;
      blsq_q    <= '0;
      esum_q    <= '0;
      asum_q    <= '0;
      cnt_q     <= '0;
      dot_neg_q <= 1'b0;
      mdot_q    <= '0;
      mx_q      <= '0;
      my_q      <= '0;
      mz_q      <= '0;
      x_q       <= '0;
      y_q       <= '0;
      z_q       <= '0;
      it_q      <= '0;
      mean_a_q  <= '0;
      mean_e_q  <= '0;
    end else begin
      state_q <= state_d;
      unique case (state_q)
        S_IDLE: if (!q_empty_i) item_q <= q_item_i;
        S_M1:   acc_q  <= prod_q;
        S_M2:   sq_q   <= SQ_W'(acc_q + prod_q);
        S_M3:   blsq_q <= prod_q[SQ_W-1:0];
        S_E1:   acc_q  <= prod_q;
        S_E3: if (!sq_busy) begin
          esum_q <= esum_q + SUM_W'(ep_sat);
          cnt_q  <= cnt_q + 1'b1;
        end
        S_A1: acc_q <= prod_q;
        S_A2: begin
          dot_neg_q <= dot[PROD_W-1];
          mdot_q    <= MAG_W'(abs_p(dot));
        end
        S_A3: acc_q <= prod_q;
        S_A4: begin
          mz_q <= MAG_W'(abs_p(cz));
          mx_q <= MAG_W'(dv_mag) << FLOW_FRAC_BITS;
          my_q <= MAG_W'(du_mag) << FLOW_FRAC_BITS;
        end
        // truncating shift on magnitudes until all fit in 31 bits
        S_SH: if (big) begin
          mdot_q <= mdot_q >> 1;
          mx_q   <= mx_q >> 1;
          my_q   <= my_q >> 1;
          mz_q   <= mz_q >> 1;
        end
        S_Q1: acc_q <= prod_q;
        S_Q2: acc_q <= acc_q + prod_q;
        S_Q4: if (!sq_busy) begin
          it_q <= '0;
          if (dot_neg_q && (mdot_q != '0)) begin
            z_q <= $signed(HALF_PI_Q30);
            x_q <= $signed(CX_W'(sq_root));
            y_q <= $signed(CX_W'(mdot_q[30:0]));
          end else begin
            z_q <= '0;
            x_q <= $signed(CX_W'(mdot_q[30:0]));
            y_q <= $signed(CX_W'(sq_root));
          end
        end
        S_CR: if (!cr_done) begin
          it_q <= it_q + 1'b1;
          if (!y_q[CX_W-1]) begin
            x_q <= x_q + dx;
            y_q <= y_q - dy;
            z_q <= z_q + $signed(atan_q30(it_q));
          end else begin
            x_q <= x_q - dx;
            y_q <= y_q + dy;
            z_q <= z_q - $signed(atan_q30(it_q));
          end
        end
        S_AC: asum_q <= asum_q + SUM_W'(ang);
        S_FIN: if (item_q.last_pixel && cnt_q == '0) begin
          mean_a_q <= '0;
          mean_e_q <= '0;
        end
        S_D1: if (!dv_busy) mean_a_q <= dv_quot[MEAN_A_W-1:0];
        S_D2: if (!dv_busy) mean_e_q <= dv_quot[MEAN_E_W-1:0];
        S_OUT: if (res_ready_i) begin
          esum_q <= '0;
          asum_q <= '0;
          cnt_q  <= '0;
        end
        default: ;
      endcase
    end
  end

  ofea_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (sq_start),
    .rad_i   (rad),
    .busy_o  (sq_busy),
    .root_o  (sq_root),
    .rem_o   (sq_rem)
  );

  ofea_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (dv_start),
    .dvd_i   (dv_dvd),
    .dvs_i   (cnt_q),
    .busy_o  (dv_busy),
    .quot_o  (dv_quot)
  );

  assign res_valid_o  = (state_q == S_OUT);
  assign res_o.mean_a = mean_a_q;
  assign res_o.mean_e = mean_e_q;
  assign res_o.count  = cnt_q[COUNT_W-1:0];
  assign stat_o.busy  = (state_q != S_IDLE);
  assign stat_o.count = cnt_q;

endmodule

`default_nettype wire

// File: rtl/core/optical_flow_error_accumulator.sv
// top level of the optical flow error accumulator: config registers, front, back, result register
// depends on ofea_pkg, ofea_front, ofea_back and optical_flow_error_accumulator_macros.svh
// per pixel word: the shared multiplier steps; a qualifying pixel adds a 32-step square root
//   and, outside band mode, normalize shifts, a second 32-step square root and up to 28
//   cordic steps
// a last pixel of a non-empty frame adds two 48-step divides before the word is handed out
// reset: async, returns registers to their defaults; sums and count clear, no clearing pass
`default_nettype none
`include "optical_flow_error_accumulator_macros.svh"

module optical_flow_error_accumulator
  import ofea_pkg::*;
#(
  parameter int unsigned MAX_PIXELS      = MAX_PIXELS_DEF,
  parameter int unsigned FLOW_FRAC_BITS  = FLOW_FRAC_DEF,
  parameter int unsigned ANGLE_FRAC_BITS = ANGLE_FRAC_DEF
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  // configuration write port
  input  wire logic                     cfg_we_i,
  input  wire logic [1:0]               cfg_idx_i,
  input  wire logic [CFG_W-1:0]         cfg_data_i,
  // pixel word queue side
  input  wire logic                     push,
  output logic                          full,
  input  wire logic signed [FLOW_W-1:0] est_u_i,
  input  wire logic signed [FLOW_W-1:0] est_v_i,
  input  wire logic signed [FLOW_W-1:0] gt_u_i,
  input  wire logic signed [FLOW_W-1:0] gt_v_i,
  input  wire logic                     occluded_i,
  input  wire logic                     last_pixel_i,
  // result word queue side
  output logic                          empty,
  input  wire logic                     pop,
  output logic [MEAN_A_W-1:0]           mean_angular_error_o,
  output logic [MEAN_E_W-1:0]           mean_endpoint_error_o,
  output logic [COUNT_W-1:0]            pixel_count_o
);

  // configuration registers
  logic [1:0]         mode_q;
  logic [LIMIT_W-1:0] limit_q;
  logic [CFG_W-1:0]   band_lo_q, band_hi_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q    <= MODE_ALL;
      limit_q   <= LIMIT_RST;
      band_lo_q <= '0;
      band_hi_q <= BAND_HI_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_MODE:    mode_q    <= cfg_data_i[1:0];
        REG_LIMIT:   limit_q   <= cfg_data_i[LIMIT_W-1:0];
        REG_BAND_LO: band_lo_q <= cfg_data_i;
        REG_BAND_HI: band_hi_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // front: limit checks and the two-entry queue
  logic       q_empty, q_pop;
  item_t      q_item;

  ofea_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .full_o       (full),
    .est_u_i      (est_u_i),
    .est_v_i      (est_v_i),
    .gt_u_i       (gt_u_i),
    .gt_v_i       (gt_v_i),
    .occluded_i   (occluded_i),
    .last_pixel_i (last_pixel_i),
    .limit_i      (limit_q),
    .pop_i        (q_pop),
    .empty_o      (q_empty),
    .item_o       (q_item)
  );

  // back: per-pixel math and frame means
  logic       res_valid, res_ready;
  res_t       res;
  back_stat_t back_stat;

  ofea_back #(
    .MAX_PIXELS      (MAX_PIXELS),
    .FLOW_FRAC_BITS  (FLOW_FRAC_BITS),
    .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_empty_i   (q_empty),
    .q_item_i    (q_item),
    .q_pop_o     (q_pop),
    .mode_i      (mode_q),
    .band_lo_i   (band_lo_q),
    .band_hi_i   (band_hi_q),
    .res_valid_o (res_valid),
    .res_o       (res),
    .res_ready_i (res_ready),
    .stat_o      (back_stat)
  );

  // result register, lets the back end go on while a word waits
  logic out_valid_q;
  res_t out_q;

  assign res_ready = !out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      if (res_valid && res_ready) begin
        out_valid_q <= 1'b1;
        out_q       <= res;
      end else if (pop && out_valid_q) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign empty                 = !out_valid_q;
  assign mean_angular_error_o  = out_q.mean_a;
  assign mean_endpoint_error_o = out_q.mean_e;
  assign pixel_count_o         = out_q.count;

  // an empty frame reports zero means
  `OFEA_ASSERT_IMPL(a_empty_frame_zero, !empty && pixel_count_o == '0,
                    mean_angular_error_o == '0 && mean_endpoint_error_o == '0)
  // the qualified count never passes the pixel cap
  `OFEA_ASSERT_ALWAYS(a_count_capped, back_stat.count <= CNT_W'(MAX_PIXELS))
  // a pixel is only taken from the queue while the back end is idle
  `OFEA_ASSERT_IMPL(a_pop_when_idle, q_pop, !back_stat.busy && !q_empty)

endmodule

`default_nettype wire

// File: sim/tb.sv
// self-checking testbench for optical_flow_error_accumulator
// depends on ofea_pkg and the accumulator rtl; holds its own model of the frame sums
`default_nettype none

module tb;
  import ofea_pkg::*;

  // one pixel word as it goes into the block
  typedef struct {
    logic signed [FLOW_W-1:0] est_u;
    logic signed [FLOW_W-1:0] est_v;
    logic signed [FLOW_W-1:0] gt_u;
    logic signed [FLOW_W-1:0] gt_v;
    logic                     occluded;
    logic                     last_pixel;
  } pixel_t;

  // one frame summary word as it comes out
  typedef struct {
    logic [MEAN_A_W-1:0] mean_a;
    logic [MEAN_E_W-1:0] mean_e;
    logic [COUNT_W-1:0]  count;
  } summary_t;

  // directed row: a pixel and, where obvious, the summary it must give
  typedef struct {
    pixel_t   pix;
    bit       fixed;
    summary_t want;
  } row_t;

  localparam int unsigned SETTLE_CYCLES = 400;   // longest pixel plus both divides, with margin
  localparam int unsigned IDLE_LIMIT    = 6000;  // cycles without any handshake
  localparam int unsigned FLOW_ONE      = 256;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     cfg_we_i = 1'b0;
  logic [1:0]               cfg_idx_i = REG_MODE;
  logic [CFG_W-1:0]         cfg_data_i = '0;
  logic                     push = 1'b0;
  logic                     full;
  logic signed [FLOW_W-1:0] est_u_i = '0;
  logic signed [FLOW_W-1:0] est_v_i = '0;
  logic signed [FLOW_W-1:0] gt_u_i = '0;
  logic signed [FLOW_W-1:0] gt_v_i = '0;
  logic                     occluded_i = 1'b0;
  logic                     last_pixel_i = 1'b0;
  logic                     empty;
  logic                     pop = 1'b0;
  logic [MEAN_A_W-1:0]      mean_angular_error_o;
  logic [MEAN_E_W-1:0]      mean_endpoint_error_o;
  logic [COUNT_W-1:0]       pixel_count_o;

  optical_flow_error_accumulator i_dut (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .cfg_we_i              (cfg_we_i),
    .cfg_idx_i             (cfg_idx_i),
    .cfg_data_i            (cfg_data_i),
    .push                  (push),
    .full                  (full),
    .est_u_i               (est_u_i),
    .est_v_i               (est_v_i),
    .gt_u_i                (gt_u_i),
    .gt_v_i                (gt_v_i),
    .occluded_i            (occluded_i),
    .last_pixel_i          (last_pixel_i),
    .empty                 (empty),
    .pop                   (pop),
    .mean_angular_error_o  (mean_angular_error_o),
    .mean_endpoint_error_o (mean_endpoint_error_o),
    .pixel_count_o         (pixel_count_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // model copy of the registers and the frame sums
  logic [1:0]          cur_mode;
  logic [LIMIT_W-1:0]  cur_limit;
  logic [CFG_W-1:0]    cur_band_lo;
  logic [CFG_W-1:0]    cur_band_hi;
  longint unsigned     angle_total;
  longint unsigned     endpoint_total;
  longint unsigned     qual_pixels;

  summary_t summary_q[$];   // summaries owed by the block, oldest first
  int unsigned mismatches = 0;
  int unsigned pixels_sent = 0;
  int unsigned summaries_seen = 0;
  int unsigned idle_cycles = 0;

  // atan(2^-i) in q30, truncated, for the first ten steps
  localparam longint ATAN_LEAD [10] = '{
    843314856, 497837829, 263043836, 133525158, 67021686,
    33543515, 16775850, 8388437, 4194282, 2097149
  };

  function automatic longint unsigned root_floor(input longint unsigned n);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n = n - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint mag_trunc_shift(input longint v, input int s);
    if (v >= 0) return v >>> s;
    return -((-v) >>> s);
  endfunction

  // angle between (est, 1) and (gt, 1), cordic in q30, rounded to q2.14
  function automatic longint unsigned flow_angle(input longint uc, input longint vc,
                                                 input longint ue, input longint ve);
    longint one;
    longint dot, cx, cy, cz, x, y, z, dx, dy, step;
    longint unsigned peak, y2;
    int s;
    one = FLOW_ONE;
    dot = uc * ue + vc * ve + one * one;
    cx = one * (vc - ve);
    cy = one * (ue - uc);
    cz = uc * ve - vc * ue;
    peak = (dot < 0) ? -dot : dot;
    if (((cx < 0) ? -cx : cx) > peak) peak = (cx < 0) ? -cx : cx;
    if (((cy < 0) ? -cy : cy) > peak) peak = (cy < 0) ? -cy : cy;
    if (((cz < 0) ? -cz : cz) > peak) peak = (cz < 0) ? -cz : cz;
    s = 0;
    while ((peak >> s) >= (64'd1 << 31)) s++;
    dot = mag_trunc_shift(dot, s);
    cx = mag_trunc_shift(cx, s);
    cy = mag_trunc_shift(cy, s);
    cz = mag_trunc_shift(cz, s);
    y2 = longint'(cx * cx) + longint'(cy * cy) + longint'(cz * cz);
    // obtuse angle: start a quarter turn in
    if (dot < 0) begin
      z = HALF_PI_Q30;
      x = root_floor(y2);
      y = -dot;
    end else begin
      z = 0;
      x = dot;
      y = root_floor(y2);
    end
    for (int i = 0; i < CORDIC_ITERS && y != 0; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      step = (i < 10) ? ATAN_LEAD[i] : (longint'(1) << (CORDIC_FRAC - i)) - 1;
      if (y > 0) begin
        x = x + dx;
        y = y - dy;
        z = z + step;
      end else begin
        x = x - dx;
        y = y + dy;
        z = z - step;
      end
    end
    if (z < 0) z = 0;
    if (z > longint'(PI_Q30)) z = PI_Q30;
    return (longint'(z) + (64'd1 << (CORDIC_FRAC - ANGLE_FRAC_DEF - 1)))
           >> (CORDIC_FRAC - ANGLE_FRAC_DEF);
  endfunction

  // add one accepted pixel to the frame sums; a last pixel closes the frame
  task automatic account_pixel(input pixel_t p, input bit fixed, input summary_t want);
    longint uc, vc, ue, ve, du, dv;
    longint unsigned lim, sq, n, r;
    bit est_ok, qual;
    summary_t got;
    uc = p.est_u;
    vc = p.est_v;
    ue = p.gt_u;
    ve = p.gt_v;
    lim = cur_limit;
    est_ok = ((uc < 0) ? -uc : uc) < lim && ((vc < 0) ? -vc : vc) < lim;
    if (cur_mode == MODE_MASKED) begin
      qual = est_ok && !p.occluded;
    end else if (cur_mode == MODE_BAND) begin
      sq = ue * ue + ve * ve;
      qual = est_ok && sq >= longint'(cur_band_lo) * cur_band_lo
                    && sq <= longint'(cur_band_hi) * cur_band_hi;
    end else begin
      // unused mode code falls back to all
      qual = est_ok && ((ue < 0) ? -ue : ue) < lim && ((ve < 0) ? -ve : ve) < lim;
    end
    if (qual && qual_pixels < MAX_PIXELS_DEF) begin
      du = (uc - ue < 0) ? ue - uc : uc - ue;
      dv = (vc - ve < 0) ? ve - vc : vc - ve;
      n = du * du + dv * dv;
      r = root_floor(n);
      if (n - r * r > r) r++;
      if (r > 64'hFFFFFF) r = 64'hFFFFFF;
      endpoint_total += r;
      if (cur_mode != MODE_BAND) angle_total += flow_angle(uc, vc, ue, ve);
      qual_pixels++;
    end
    if (p.last_pixel) begin
      if (qual_pixels == 0) begin
        got.mean_a = '0;
        got.mean_e = '0;
      end else begin
        got.mean_a = MEAN_A_W'(angle_total / qual_pixels);
        got.mean_e = MEAN_E_W'(endpoint_total / qual_pixels);
      end
      got.count = COUNT_W'(qual_pixels);
      summary_q.push_back(fixed ? want : got);
      angle_total = 0;
      endpoint_total = 0;
      qual_pixels = 0;
    end
  endtask

  // mostly back to back, sometimes a short gap, now and then a long pause
  function automatic int pick_gap();
    int k;
    k = $urandom_range(0, 99);
    if (k < 55) return 0;
    if (k < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_pixel(input pixel_t p, input bit fixed, input summary_t want);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push <= 1'b1;
    est_u_i <= p.est_u;
    est_v_i <= p.est_v;
    gt_u_i <= p.gt_u;
    gt_v_i <= p.gt_v;
    occluded_i <= p.occluded;
    last_pixel_i <= p.last_pixel;
    do @(posedge clk_i); while (full);
    pixels_sent++;
    account_pixel(p, fixed, want);
  endtask

  // register write; junk above the register width must be dropped
  task automatic write_reg(input logic [1:0] idx, input logic [CFG_W-1:0] value);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_MODE:    cur_mode = value[1:0];
      REG_LIMIT:   cur_limit = value[LIMIT_W-1:0];
      REG_BAND_LO: cur_band_lo = value;
      default:     cur_band_hi = value;
    endcase
  endtask

  task automatic drain();
    while (summary_q.size() > 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // flow component: small, around the limit, extreme or any 24-bit value
  function automatic logic signed [FLOW_W-1:0] pick_flow(input logic [LIMIT_W-1:0] lim);
    int k;
    k = $urandom_range(0, 99);
    if (k < 45) return FLOW_W'($urandom_range(0, 6000)) - FLOW_W'(3000);
    if (k < 60) return FLOW_W'($urandom_range(0, 2 * 4000)) - FLOW_W'(4000)
                       + (($urandom_range(0, 1)) ? FLOW_W'(lim) : -FLOW_W'(lim));
    if (k < 70) return $urandom_range(0, 1) ? 24'sh7FFFFF : 24'sh800000;
    return FLOW_W'($urandom);
  endfunction

  function automatic pixel_t pick_pixel(input bit last);
    pixel_t p;
    p.est_u = pick_flow(cur_limit);
    p.est_v = pick_flow(cur_limit);
    // ground truth often close to the estimate, so errors stay realistic
    if ($urandom_range(0, 2) != 0) begin
      p.gt_u = p.est_u + FLOW_W'($urandom_range(0, 1200)) - FLOW_W'(600);
      p.gt_v = p.est_v + FLOW_W'($urandom_range(0, 1200)) - FLOW_W'(600);
    end else begin
      p.gt_u = pick_flow(cur_limit);
      p.gt_v = pick_flow(cur_limit);
    end
    p.occluded = $urandom_range(0, 3) == 0;
    p.last_pixel = last;
    return p;
  endfunction

  // random frames under one register setting, ends on a last pixel
  task automatic run_frames(input int unsigned pixels);
    int unsigned left, len;
    summary_t none;
    none = '{default: '0};
    left = pixels;
    while (left > 0) begin
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 30) : $urandom_range(1, 8);
      if (len > left) len = left;
      for (int unsigned j = 1; j <= len; j++) send_pixel(pick_pixel(j == len), 1'b0, none);
      left -= len;
    end
  endtask

  function automatic logic [CFG_W-1:0] with_junk(input logic [CFG_W-1:0] v, input int w);
    logic [CFG_W-1:0] junk;
    junk = CFG_W'($urandom) << w;
    return ($urandom_range(0, 1) != 0) ? (v | junk) : v;
  endfunction

  task automatic set_regs(input logic [1:0] m, input logic [LIMIT_W-1:0] lim,
                          input logic [CFG_W-1:0] lo, input logic [CFG_W-1:0] hi);
    write_reg(REG_MODE, with_junk(CFG_W'(m), 2));
    write_reg(REG_LIMIT, with_junk(CFG_W'(lim), LIMIT_W));
    write_reg(REG_BAND_LO, lo);
    write_reg(REG_BAND_HI, hi);
  endtask

  // result side: random stalls, with long stretches of steady popping
  int unsigned pop_hold = 0;
  bit steady = 1'b0;
  always @(posedge clk_i) begin
    if (pop_hold > 0) begin
      pop <= 1'b0;
      pop_hold <= pop_hold - 1;
    end else if (steady) begin
      pop <= 1'b1;
      if ($urandom_range(0, 199) == 0) steady <= 1'b0;
    end else begin
      pop <= 1'b1;
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4, 5: pop_hold <= $urandom_range(1, 3);
        6:                pop_hold <= $urandom_range(15, 40);
        7:                steady <= 1'b1;
        default:          ;
      endcase
    end
  end

  // compare each popped summary word with the oldest one owed
  always @(posedge clk_i) begin
    summary_t want;
    if (rst_ni && pop && !empty) begin
      summaries_seen++;
      if (summary_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected summary word: %0d %0d %0d",
          mean_angular_error_o, mean_endpoint_error_o, pixel_count_o);
      end else begin
        want = summary_q.pop_front();
        if (mean_angular_error_o !== want.mean_a || mean_endpoint_error_o !== want.mean_e
            || pixel_count_o !== want.count) begin
          mismatches++;
          if (mismatches <= 10)
            $display("summary %0d: angle %0d/%0d endpoint %0d/%0d count %0d/%0d (exp/got)",
              summaries_seen, want.mean_a, mean_angular_error_o, want.mean_e,
              mean_endpoint_error_o, want.count, pixel_count_o);
        end
      end
    end
  end

  // watchdog: any accepted word restarts the count
  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("stalled for %0d cycles, %0d summaries owed", idle_cycles, summary_q.size());
      $display("tb: errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic row_t mk_row(input int eu, input int ev, input int gu, input int gv,
                                  input bit occ, input bit last, input bit fixed,
                                  input int ma, input int me, input int cnt);
    row_t r;
    r.pix = '{est_u: FLOW_W'(eu), est_v: FLOW_W'(ev), gt_u: FLOW_W'(gu), gt_v: FLOW_W'(gv),
              occluded: occ, last_pixel: last};
    r.fixed = fixed;
    r.want = '{mean_a: MEAN_A_W'(ma), mean_e: MEAN_E_W'(me), count: COUNT_W'(cnt)};
    return r;
  endfunction

  row_t rows[$];

  initial begin
    cur_mode = MODE_ALL;
    cur_limit = LIMIT_RST;
    cur_band_lo = '0;
    cur_band_hi = BAND_HI_RST;
    angle_total = 0;
    endpoint_total = 0;
    qual_pixels = 0;

    // reset defaults: mode all, limit 10000 px
    rows.push_back(mk_row(-8388608, 0, 0, 0, 0, 1, 1, 0, 0, 0));   // empty frame
    rows.push_back(mk_row(0, 0, 0, 0, 0, 1, 1, 0, 0, 1));          // zero flow
    rows.push_back(mk_row(1000, -700, 1000, -700, 0, 1, 1, 0, 0, 1));  // parallel
    rows.push_back(mk_row(2559999, -2559999, 2559999, -2559999, 1, 1, 1, 0, 0, 1));
    rows.push_back(mk_row(2560000, 0, 0, 0, 0, 1, 1, 0, 0, 0));    // at the limit
    rows.push_back(mk_row(5, 5, 5, -8388608, 0, 1, 1, 0, 0, 0));   // bad ground truth
    rows.push_back(mk_row(8388607, 8388607, 8388607, 8388607, 0, 1, 1, 0, 0, 0));
    rows.push_back(mk_row(0, 0, 256, 0, 0, 0, 0, 0, 0, 0));
    rows.push_back(mk_row(2560, 0, -2560, 0, 0, 0, 0, 0, 0, 0));   // opposite vectors
    rows.push_back(mk_row(100, 200, -300, 50, 1, 1, 0, 0, 0, 0));
    rows.push_back(mk_row(-2559999, 2559999, 2559999, -2559999, 0, 1, 0, 0, 0, 0));
    rows.push_back(mk_row(-2559999, -2559999, 0, 0, 0, 0, 0, 0, 0, 0));
    rows.push_back(mk_row(1, -1, -1, 1, 0, 1, 0, 0, 0, 0));

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i]) send_pixel(rows[i].pix, rows[i].fixed, rows[i].want);
    push <= 1'b0;
    drain();

    // register settings, extremes among them; each one ends on a frame boundary
    set_regs(MODE_ALL, LIMIT_RST, '0, BAND_HI_RST);
    run_frames(100);
    push <= 1'b0;
    drain();
    set_regs(MODE_MASKED, LIMIT_RST, '0, BAND_HI_RST);
    run_frames(100);
    push <= 1'b0;
    drain();
    set_regs(MODE_BAND, LIMIT_RST, 24'd256, 24'd3000);
    run_frames(100);
    push <= 1'b0;
    drain();
    set_regs(MODE_BAND, 23'h7FFFFF, '0, 24'hFFFFFF);
    run_frames(80);
    push <= 1'b0;
    drain();
    set_regs(2'd3, 23'h7FFFFF, 24'd5, 24'd1);   // unused mode code, inverted band
    run_frames(80);
    push <= 1'b0;
    drain();
    set_regs(MODE_BAND, 23'd3000, 24'd9000, 24'd100);   // inverted band lets nothing in
    run_frames(60);
    push <= 1'b0;
    drain();
    set_regs(MODE_ALL, '0, 24'hFFFFFF, '0);   // zero limit rejects every pixel
    run_frames(60);
    push <= 1'b0;
    drain();
    set_regs(MODE_MASKED, 23'd2000, 24'd1000, 24'd5000);
    run_frames(80);
    push <= 1'b0;
    drain();
    set_regs(MODE_ALL, 23'd4000, '0, BAND_HI_RST);
    run_frames(90);
    push <= 1'b0;
    drain();

    $display("sent %0d pixel words, checked %0d frame summaries over ten register settings",
             pixels_sent, summaries_seen);
    if (mismatches == 0 && summary_q.size() == 0) begin
      $display("tb: clean");
    end else begin
      $display("%0d mismatches, %0d summaries never came", mismatches, summary_q.size());
      $display("tb: errors");
    end
    $finish;
  end

endmodule

`default_nettype wire
